// ----- hdl/running_median_sample_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Running median sample filter: assertion macros
// Shared assertion wrappers, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_SAMPLE_FILTER_DEFINES_SVH
`define RUNNING_MEDIAN_SAMPLE_FILTER_DEFINES_SVH

// The property holds in every cycle.
`define RMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rmf assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmf assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define RMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmf assertion failed");

`endif

// ----- hdl/rmf_pkg.sv -----
// ----------------------------------------------------------------------------
// Running median sample filter: package
// Sizes, payload types and the link records passed between sorting cells.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int Window     = 15;
  localparam int SampleBits = 10;
  localparam int AdcW       = 10;
  localparam int CountFldW  = 4;
  localparam int AgeW       = (Window > 1) ? $clog2(Window) : 1;
  localparam int CntW       = $clog2(Window + 1);

  typedef struct packed {
    logic [AdcW-1:0] adc_sample;
    logic            sample_valid;
  } in_payload_t;

  typedef struct packed {
    logic [AdcW-1:0]      median_value;
    logic [CountFldW-1:0] window_count;
  } out_payload_t;

  // Passed from a cell to its upper neighbor.
  typedef struct packed {
    logic [SampleBits-1:0] val;
    logic [AgeW-1:0]       age;
    logic                  occ;
    logic                  lt;
    logic                  gap;
    logic                  drop;
    logic [SampleBits-1:0] tap_lo;
    logic [SampleBits-1:0] tap_hi;
  } cell_up_t;

  // Passed from a cell to its lower neighbor.
  typedef struct packed {
    logic [SampleBits-1:0] val;
    logic [AgeW-1:0]       age;
    logic                  le;
  } cell_dn_t;

endpackage

// ----- hdl/rmf_stream_if.sv -----
// ----------------------------------------------------------------------------
// Running median sample filter: stream interfaces
// Valid/ready channels for incoming samples and outgoing medians.
// ----------------------------------------------------------------------------
interface rmf_in_if;
  logic                 valid;
  logic                 ready;
  rmf_pkg::in_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rmf_out_if;
  logic                  valid;
  logic                  ready;
  rmf_pkg::out_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/rmf_cell.sv -----
// ----------------------------------------------------------------------------
// Running median sample filter: sorting cell
// One slot of the sorted window. Holds a sample and its age, and on an insert
// takes its next content from itself, a neighbor or the new sample.
// ----------------------------------------------------------------------------
module rmf_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rmf_pkg::AgeW-1:0]          idx_i,
  input  logic [rmf_pkg::SampleBits-1:0]    sample_i,
  input  logic                              insert_i,
  input  logic                              full_i,
  input  logic [rmf_pkg::AgeW-1:0]          lo_idx_i,
  input  logic [rmf_pkg::AgeW-1:0]          hi_idx_i,
  input  rmf_pkg::cell_up_t                 up_i,
  output rmf_pkg::cell_up_t                 up_o,
  input  rmf_pkg::cell_dn_t                 dn_i,
  output rmf_pkg::cell_dn_t                 dn_o
);

  logic [rmf_pkg::SampleBits-1:0] val_q, val_d;
  logic [rmf_pkg::AgeW-1:0]       age_q, age_d;
  logic                           occ_q, occ_d;
  logic                           drop, le, gap, lt, ins;
  logic [rmf_pkg::AgeW-1:0]       src_age;

  assign drop = full_i && occ_q && (age_q == rmf_pkg::AgeW'(rmf_pkg::Window - 1));
  assign le   = occ_q && !drop && (val_q <= sample_i);
  assign gap  = up_i.gap || drop;
  assign lt   = gap ? dn_i.le : le;
  assign ins  = !lt && up_i.lt;

  always_comb begin
    val_d   = val_q;
    age_d   = age_q;
    src_age = age_q;
    occ_d   = occ_q;
    if (insert_i) begin
      occ_d = full_i ? occ_q : (occ_q || up_i.occ);
      if (lt) begin
        if (gap) begin
          val_d   = dn_i.val;
          src_age = dn_i.age;
        end else begin
          src_age = age_q;
        end
        age_d = src_age + 1'b1;
      end else if (ins) begin
        val_d = sample_i;
        age_d = '0;
      end else begin
        if (!up_i.gap) begin
          val_d   = up_i.val;
          src_age = up_i.age;
        end
        age_d = src_age + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

  always_comb begin
    up_o.val    = val_q;
    up_o.age    = age_q;
    up_o.occ    = occ_q;
    up_o.lt     = lt;
    up_o.gap    = gap;
    up_o.drop   = drop;
    up_o.tap_lo = up_i.tap_lo | ((occ_q && idx_i == lo_idx_i) ? val_q : '0);
    up_o.tap_hi = up_i.tap_hi | ((occ_q && idx_i == hi_idx_i) ? val_q : '0);
    dn_o.val    = val_q;
    dn_o.age    = age_q;
    dn_o.le     = le;
  end

endmodule

// ----- hdl/running_median_sample_filter.sv -----
// ----------------------------------------------------------------------------
// Running median sample filter: top level
// Each transaction carries one converter sample. A valid sample enters a
// sliding window of the last 15 samples, kept sorted in a chain of 15 cells
// that drop the oldest sample and insert the new one in the same cycle. Each
// transaction returns the window median and fill count. The sorted chain is
// updated in the cycle a transaction is accepted; the median is registered
// from the pending transaction once the output register is free or being
// drained, and the input takes no new transaction while one is pending. A
// finished result waiting at the output does not hold back the next input
// transaction.
// ----------------------------------------------------------------------------
`include "running_median_sample_filter_defines.svh"

module running_median_sample_filter (
  input  logic             clk_i,
  input  logic             rst_ni,
  rmf_in_if.sink           in_i,
  rmf_out_if.source        out_o
);

  logic                                 accept, load, insert, full;
  logic                                 pend_q;
  logic                                 out_valid_q;
  rmf_pkg::out_payload_t                out_q;
  logic [rmf_pkg::CntW-1:0]             count_q;
  logic [rmf_pkg::SampleBits-1:0]       sample;
  logic [rmf_pkg::AgeW-1:0]             lo_idx, hi_idx;
  logic [rmf_pkg::SampleBits:0]         pair_sum;
  logic [rmf_pkg::SampleBits-1:0]       median;
  logic [rmf_pkg::Window-1:0]           occ_vec, drop_vec;
  rmf_pkg::cell_up_t                    up_link [0:rmf_pkg::Window];
  rmf_pkg::cell_dn_t                    dn_link [0:rmf_pkg::Window];

  assign in_i.ready = !pend_q;
  assign accept     = in_i.valid && !pend_q;
  assign insert     = accept && in_i.payload.sample_valid;
  assign sample     = rmf_pkg::SampleBits'(in_i.payload.adc_sample);
  assign load       = pend_q && (!out_valid_q || out_o.ready);
  assign full       = up_link[rmf_pkg::Window].occ;

  assign lo_idx = rmf_pkg::AgeW'((count_q - 1'b1) >> 1);
  assign hi_idx = rmf_pkg::AgeW'(count_q >> 1);

  always_comb begin
    up_link[0]                 = '0;
    up_link[0].occ             = 1'b1;
    up_link[0].lt              = 1'b1;
    dn_link[rmf_pkg::Window]   = '0;
  end

  for (genvar i = 0; i < rmf_pkg::Window; i++) begin : g_cell
    rmf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (rmf_pkg::AgeW'(i)),
      .sample_i (sample),
      .insert_i (insert),
      .full_i   (full),
      .lo_idx_i (lo_idx),
      .hi_idx_i (hi_idx),
      .up_i     (up_link[i]),
      .up_o     (up_link[i+1]),
      .dn_i     (dn_link[i+1]),
      .dn_o     (dn_link[i])
    );
    assign occ_vec[i]  = up_link[i+1].occ;
    assign drop_vec[i] = up_link[i+1].drop;
  end

  assign pair_sum = {1'b0, up_link[rmf_pkg::Window].tap_lo}
                  + {1'b0, up_link[rmf_pkg::Window].tap_hi};
  assign median   = (count_q == '0) ? '0 : pair_sum[rmf_pkg::SampleBits:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (insert && count_q != rmf_pkg::CntW'(rmf_pkg::Window)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.median_value <= rmf_pkg::AdcW'(median);
      out_q.window_count <= rmf_pkg::CountFldW'(count_q);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `RMF_ASSERT_NEXT(a_accept_pending, accept, pend_q)
  `RMF_ASSERT_NEXT(a_count_grows, insert && count_q != rmf_pkg::CntW'(rmf_pkg::Window),
    count_q == rmf_pkg::CntW'($past(count_q) + 1'b1))
  `RMF_ASSERT(a_occ_matches_count, $countones(occ_vec) == count_q)
  `RMF_ASSERT_IMPL(a_one_oldest_when_full, full, $onehot(drop_vec))
  `RMF_ASSERT_IMPL(a_result_from_pending, $rose(out_valid_q), $past(pend_q))

endmodule
